// ===== hw/rtl/bscc_pkg.sv =====
package bscc_pkg;

   localparam int DEF_MAX_FEATURES = 256;
   localparam int DEF_NODE_DEPTH   = 4096;
   localparam int DEF_WEIGHT_DEPTH = 4096;
   localparam int DEF_MAX_CLASSES  = 16;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [7:0] CHAIN_CODE = 8'hff;

   typedef enum logic [1:0] {
      FUNC_NODE    = 2'd0,
      FUNC_WEIGHT  = 2'd1,
      FUNC_CLASS   = 2'd2,
      FUNC_FEATURE = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [11:0]        addr;
      logic [7:0]         node_dim;
      logic signed [15:0] node_thr;
      logic [7:0]         left_leaf;
      logic [7:0]         right_leaf;
      logic signed [15:0] data_value;
      logic [8:0]         tree_count;
      logic [7:0]         split_count;
      logic [11:0]        node_base;
      logic [11:0]        weight_base;
      logic               last_feature;
   } item_type;

   typedef struct packed {
      logic push;
      logic full;
   } queue_ctl_type;

endpackage

// ===== hw/rtl/bscc_front.sv =====
module bscc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bscc_pkg::item_type item,
   input  logic               queue_full,
   input  logic               back_busy,
   input  logic               queue_empty,
   output bscc_pkg::queue_ctl_type ctl,
   output bscc_pkg::item_type q_item
);
   import bscc_pkg::*;

   logic eval_pending_ff, eval_pending_in;
   logic accept;

   // an evaluation blocks new items until the queue drains and the back is idle
   assign busy   = queue_full || eval_pending_ff;
   assign accept = start && !busy;
   assign q_item = item;
   assign ctl.push = accept;
   assign ctl.full = queue_full;

   always_comb begin
      eval_pending_in = eval_pending_ff;
      if (accept && item.func == FUNC_FEATURE && item.last_feature) begin
         eval_pending_in = 1'b1;
      end else if (eval_pending_ff && queue_empty && !back_busy) begin
         eval_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_pending_ff <= 1'b0;
      end else begin
         eval_pending_ff <= eval_pending_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) ctl.push |-> !queue_full)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset)
      (accept && item.func == FUNC_FEATURE && item.last_feature) |=> busy)
      else $error("not busy after last feature");
   assert property (@(posedge clock) disable iff (reset) eval_pending_ff |-> busy)
      else $error("accept during evaluation");
endmodule

// ===== hw/rtl/bscc_queue.sv =====
module bscc_queue #(
   parameter int DEPTH = bscc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  bscc_pkg::queue_ctl_type ctl,
   input  bscc_pkg::item_type wdata,
   input  logic               pop,
   output bscc_pkg::item_type rdata,
   output logic               empty,
   output logic               full
);
   import bscc_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type        slot_ff [DEPTH];
   logic [AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]     cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign rdata = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (ctl.push) begin
         wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      end
      if (pop) begin
         rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      if (ctl.push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!ctl.push && pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         slot_ff[wp_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (ctl.push && !pop && !full) |=> !empty)
      else $error("queue lost item");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= (AW+1)'(DEPTH))
      else $error("queue count overflow");
endmodule

// ===== hw/rtl/bscc_back.sv =====
module bscc_back #(
   parameter int MAX_FEATURES = bscc_pkg::DEF_MAX_FEATURES,
   parameter int NODE_DEPTH   = bscc_pkg::DEF_NODE_DEPTH,
   parameter int WEIGHT_DEPTH = bscc_pkg::DEF_WEIGHT_DEPTH,
   parameter int MAX_CLASSES  = bscc_pkg::DEF_MAX_CLASSES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [4:0]         class_count,
   input  bscc_pkg::item_type item,
   input  logic               queue_empty,
   output logic               pop,
   output logic               back_busy,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_class_label,
   output logic [4:0]         rsp_match_count,
   output logic               rsp_model_error
);
   import bscc_pkg::*;

   localparam int FW = $clog2(MAX_FEATURES);
   localparam int NW = $clog2(NODE_DEPTH);
   localparam int WW = $clog2(WEIGHT_DEPTH);
   localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int KW = $clog2(MAX_CLASSES + 1);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_CLASS  = 10'b0000000010,
      S_CREAD  = 10'b0000000100,
      S_NODE   = 10'b0000001000,
      S_FEAT   = 10'b0000010000,
      S_CMP    = 10'b0000100000,
      S_WEIGHT = 10'b0001000000,
      S_ADD    = 10'b0010000000,
      S_JUDGE  = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic [7:0]         dim;
      logic signed [15:0] thr;
      logic [7:0]         left;
      logic [7:0]         right;
   } node_type;

   typedef struct packed {
      logic signed [15:0] label;
      logic [8:0]         trees;
      logic [7:0]         splits;
      logic [11:0]        nbase;
      logic [11:0]        wbase;
   } crec_type;

   logic signed [15:0] feat_mem [MAX_FEATURES];
   node_type           node_mem [NODE_DEPTH];
   logic signed [15:0] wgt_mem  [WEIGHT_DEPTH];
   crec_type           cls_mem  [MAX_CLASSES];

   state_type          state_ff, state_in;
   logic [FW:0]        fill_ff, fill_in;
   logic [KW-1:0]      k_ff, k_in, ncls;
   logic [8:0]         t_ff, t_in;
   logic [7:0]         s_ff, s_in;
   logic [NW-1:0]      nptr_ff, nptr_in, tptr_ff, tptr_in;
   logic [WW-1:0]      wptr_ff, wptr_in;
   logic [KW-1:0]      match_ff, match_in;
   logic               err_ff, err_in;
   logic signed [15:0] label_ff, label_in;
   logic signed [31:0] sum_ff, sum_in;
   logic [7:0]         leaf_ff, leaf_in;
   crec_type           crec_ff;
   node_type           node_ff;
   logic signed [15:0] feat_ff, wgt_ff;
   logic               dim_ok_ff;
   logic               go_eval;
   logic               tree_end;
   logic [CW-1:0]      cidx;

   assign back_busy = (state_ff != S_IDLE);
   assign pop       = (state_ff == S_IDLE) && !queue_empty;
   assign go_eval   = pop && item.func == FUNC_FEATURE && item.last_feature;
   assign ncls = (32'(class_count) > MAX_CLASSES) ? KW'(MAX_CLASSES) : KW'(class_count);
   assign cidx = CW'(k_ff);

   always_ff @(posedge clock) begin
      if (pop && item.func == FUNC_NODE) begin
         node_mem[NW'(item.addr)] <= '{item.node_dim, item.node_thr,
                                       item.left_leaf, item.right_leaf};
      end
      if (pop && item.func == FUNC_WEIGHT) begin
         wgt_mem[WW'(item.addr)] <= item.data_value;
      end
      if (pop && item.func == FUNC_CLASS && 32'(item.addr) < MAX_CLASSES) begin
         cls_mem[CW'(item.addr)] <= '{item.data_value, item.tree_count,
                                      item.split_count, item.node_base, item.weight_base};
      end
      if (pop && item.func == FUNC_FEATURE && fill_ff < (FW+1)'(MAX_FEATURES)) begin
         feat_mem[FW'(fill_ff)] <= item.data_value;
      end
      crec_ff   <= cls_mem[cidx];
      node_ff   <= node_mem[nptr_ff];
      feat_ff   <= feat_mem[FW'(node_ff.dim)];
      dim_ok_ff <= (32'(node_ff.dim) < MAX_FEATURES);
      wgt_ff    <= wgt_mem[wptr_ff + WW'(leaf_ff)];
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      k_in     = k_ff;
      t_in     = t_ff;
      s_in     = s_ff;
      nptr_in  = nptr_ff;
      tptr_in  = tptr_ff;
      wptr_in  = wptr_ff;
      match_in = match_ff;
      err_in   = err_ff;
      label_in = label_ff;
      sum_in   = sum_ff;
      leaf_in  = leaf_ff;
      tree_end = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pop && item.func == FUNC_FEATURE && fill_ff < (FW+1)'(MAX_FEATURES)) begin
               fill_in = fill_ff + 1'b1;
            end
            if (go_eval) begin
               fill_in  = '0;
               k_in     = '0;
               match_in = '0;
               err_in   = 1'b0;
               label_in = -16'sd1;
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            if (k_ff >= ncls) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CREAD;
            end
         end
         S_CREAD: begin
            t_in    = '0;
            s_in    = '0;
            sum_in  = '0;
            nptr_in = NW'(crec_ff.nbase);
            tptr_in = NW'(crec_ff.nbase);
            wptr_in = WW'(crec_ff.wbase);
            if (crec_ff.trees == '0) begin
               state_in = S_JUDGE;
            end else if (crec_ff.splits == '0) begin
               err_in   = 1'b1;
               state_in = S_JUDGE;
            end else begin
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            state_in = S_FEAT;
         end
         S_FEAT: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            leaf_in = ((dim_ok_ff ? feat_ff : 16'sd0) >= node_ff.thr) ? node_ff.right
                                                                        : node_ff.left;
            state_in = S_WEIGHT;
         end
         S_WEIGHT: begin
            if (leaf_ff != CHAIN_CODE) begin
               state_in = S_ADD;
            end else if (s_ff + 8'd1 == crec_ff.splits) begin
               err_in   = 1'b1;
               tree_end = 1'b1;
            end else begin
               s_in     = s_ff + 8'd1;
               nptr_in  = nptr_ff + NW'(1);
               state_in = S_NODE;
            end
         end
         S_ADD: begin
            sum_in   = sum_ff + 32'(wgt_ff);
            tree_end = 1'b1;
         end
         S_JUDGE: begin
            if (sum_ff > 32'sd0) begin
               match_in = match_ff + 1'b1;
               label_in = crec_ff.label;
            end
            k_in     = k_ff + 1'b1;
            state_in = S_CLASS;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (tree_end) begin
         tptr_in  = tptr_ff + NW'(crec_ff.splits);
         nptr_in  = tptr_ff + NW'(crec_ff.splits);
         wptr_in  = wptr_ff + WW'({1'b0, crec_ff.splits} + 9'd1);
         s_in     = '0;
         t_in     = t_ff + 9'd1;
         state_in = (t_ff + 9'd1 == crec_ff.trees) ? S_JUDGE : S_NODE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         fill_ff         <= '0;
         k_ff            <= '0;
         t_ff            <= '0;
         s_ff            <= '0;
         nptr_ff         <= '0;
         tptr_ff         <= '0;
         wptr_ff         <= '0;
         match_ff        <= '0;
         err_ff          <= 1'b0;
         label_ff        <= -16'sd1;
         sum_ff          <= '0;
         leaf_ff         <= '0;
         rsp_valid       <= 1'b0;
         rsp_class_label <= '0;
         rsp_match_count <= '0;
         rsp_model_error <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         k_ff      <= k_in;
         t_ff      <= t_in;
         s_ff      <= s_in;
         nptr_ff   <= nptr_in;
         tptr_ff   <= tptr_in;
         wptr_ff   <= wptr_in;
         match_ff  <= match_in;
         err_ff    <= err_in;
         label_ff  <= label_in;
         sum_ff    <= sum_in;
         leaf_ff   <= leaf_in;
         rsp_valid <= (state_ff == S_DONE);
         if (state_ff == S_DONE) begin
            rsp_class_label <= (match_ff == KW'(1)) ? label_ff : -16'sd1;
            rsp_match_count <= 5'(match_ff);
            rsp_model_error <= err_ff;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !pop)
      else $error("result during item intake");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_match_count) <= MAX_CLASSES)
      else $error("match count too large");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid)
      else $error("missing result");
   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
endmodule

// ===== hw/rtl/boosted_stump_chain_classifier.sv =====
// Boosted stump-chain classifier. Items enter through start/busy; a front stage
// queues up to four items while the back stage writes the tables and walks trees.
// The back stage takes table writes and features straight from the queue, so items
// flow at one per cycle up to the final feature while busy stays low. Once the final
// feature leaves the queue, the back stage walks the trees of each class in turn,
// reading the node, feature and weight memories one after another; busy stays high
// until the result strobe has gone out. rsp_valid is high for one cycle and the
// receiver cannot stall it.
module boosted_stump_chain_classifier #(
   parameter int MAX_FEATURES = bscc_pkg::DEF_MAX_FEATURES,
   parameter int NODE_DEPTH   = bscc_pkg::DEF_NODE_DEPTH,
   parameter int WEIGHT_DEPTH = bscc_pkg::DEF_WEIGHT_DEPTH,
   parameter int MAX_CLASSES  = bscc_pkg::DEF_MAX_CLASSES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic [11:0]        req_addr,
   input  logic [7:0]         req_node_dim,
   input  logic signed [15:0] req_node_thr,
   input  logic [7:0]         req_left_leaf,
   input  logic [7:0]         req_right_leaf,
   input  logic signed [15:0] req_data_value,
   input  logic [8:0]         req_tree_count,
   input  logic [7:0]         req_split_count,
   input  logic [11:0]        req_node_base,
   input  logic [11:0]        req_weight_base,
   input  logic               req_last_feature,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_class_count,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_class_label,
   output logic [4:0]         rsp_match_count,
   output logic               rsp_model_error
);
   import bscc_pkg::*;

   item_type      in_item, q_wdata, q_rdata;
   queue_ctl_type ctl;
   logic          q_empty, q_full, pop, back_busy;
   logic [4:0]    class_count_ff;

   assign csr_ready = 1'b1;
   assign in_item = '{req_func, req_addr, req_node_dim, req_node_thr, req_left_leaf,
                      req_right_leaf, req_data_value, req_tree_count, req_split_count,
                      req_node_base, req_weight_base, req_last_feature};

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= 5'd1;
      end else if (csr_valid && csr_ready) begin
         class_count_ff <= csr_class_count;
      end
   end

   bscc_front u_front (
      .clock, .reset, .start, .busy, .item(in_item), .queue_full(q_full),
      .back_busy, .queue_empty(q_empty), .ctl, .q_item(q_wdata)
   );

   bscc_queue u_queue (
      .clock, .reset, .ctl, .wdata(q_wdata), .pop, .rdata(q_rdata),
      .empty(q_empty), .full(q_full)
   );

   bscc_back #(
      .MAX_FEATURES(MAX_FEATURES), .NODE_DEPTH(NODE_DEPTH),
      .WEIGHT_DEPTH(WEIGHT_DEPTH), .MAX_CLASSES(MAX_CLASSES)
   ) u_back (
      .clock, .reset, .class_count(class_count_ff), .item(q_rdata),
      .queue_empty(q_empty), .pop, .back_busy, .rsp_valid, .rsp_class_label,
      .rsp_match_count, .rsp_model_error
   );
endmodule

// ===== test/boosted_stump_chain_classifier_test.sv =====
`timescale 1ns / 100ps

module boosted_stump_chain_classifier_test;
   import bscc_pkg::*;

   localparam int NUM_ITEMS   = 1850;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 40;

   typedef struct packed {
      logic signed [15:0] label;
      logic [4:0]         hits;
      logic               err;
   } verdict_type;

   typedef struct {
      item_type    it;
      bit          typed;
      verdict_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [4:0] csr_class_count = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_class_label;
   logic [4:0] rsp_match_count;
   logic rsp_model_error;
   item_type cur = '0;

   // stump table, leaf weights, class records and features as the block holds them
   logic [7:0]         stump_dim [4096];
   logic signed [15:0] stump_thr [4096];
   logic [7:0]         stump_left [4096];
   logic [7:0]         stump_right [4096];
   logic signed [15:0] leaf_weight [4096];
   logic signed [15:0] cls_label [16];
   logic [8:0]         cls_trees [16];
   logic [7:0]         cls_splits [16];
   logic [11:0]        cls_nbase [16];
   logic [11:0]        cls_wbase [16];
   logic signed [15:0] features [256];
   bit                 feature_seen [256];
   int                 fill_index = 0;
   logic [4:0]         classes_reg = 5'd1;

   verdict_type pending[$];
   int errors = 0;
   int results = 0;
   int items = 0;
   int vectors = 0;
   int phases = 0;
   int cycles = 0;
   bit no_gaps = 1'b0;

   boosted_stump_chain_classifier dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(cur.func), .req_addr(cur.addr), .req_node_dim(cur.node_dim),
      .req_node_thr(cur.node_thr), .req_left_leaf(cur.left_leaf),
      .req_right_leaf(cur.right_leaf), .req_data_value(cur.data_value),
      .req_tree_count(cur.tree_count), .req_split_count(cur.split_count),
      .req_node_base(cur.node_base), .req_weight_base(cur.weight_base),
      .req_last_feature(cur.last_feature),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_class_count(csr_class_count),
      .rsp_valid(rsp_valid), .rsp_class_label(rsp_class_label),
      .rsp_match_count(rsp_match_count), .rsp_model_error(rsp_model_error)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch @%0t: %s", $realtime, what);
      errors++;
   endtask

   always @(posedge clock) begin
      verdict_type w;
      if (!reset && rsp_valid) begin
         if (pending.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            w = pending.pop_front();
            results++;
            if (rsp_class_label !== w.label)
               report_mismatch($sformatf("class_label %0d, want %0d", rsp_class_label,
                                         w.label));
            if (rsp_match_count !== w.hits)
               report_mismatch($sformatf("match_count %0d, want %0d", rsp_match_count,
                                         w.hits));
            if (rsp_model_error !== w.err)
               report_mismatch($sformatf("model_error %0b, want %0b", rsp_model_error,
                                         w.err));
         end
      end
   end

   function automatic int walk_chain(input logic [3:0] k, input int t, inout bit err);
      int nstart;
      int wstart;
      logic [11:0] node;
      logic signed [15:0] f;
      logic [7:0] leaf;
      nstart = cls_nbase[k] + t * cls_splits[k];
      wstart = cls_wbase[k] + t * (cls_splits[k] + 1);
      for (int s = 0; s < cls_splits[k]; s++) begin
         node = 12'((nstart + s) % 4096);
         f = features[stump_dim[node]];
         leaf = (f >= stump_thr[node]) ? stump_right[node] : stump_left[node];
         if (leaf != CHAIN_CODE)
            return leaf_weight[12'((wstart + leaf) % 4096)];
      end
      err = 1'b1;
      return 0;
   endfunction

   task automatic classify_item(input item_type it, output bit got, output verdict_type v);
      int ncls;
      int score;
      got = 1'b0;
      v = '0;
      case (func_type'(it.func))
         FUNC_NODE: begin
            stump_dim[it.addr] = it.node_dim;
            stump_thr[it.addr] = it.node_thr;
            stump_left[it.addr] = it.left_leaf;
            stump_right[it.addr] = it.right_leaf;
         end
         FUNC_WEIGHT: leaf_weight[it.addr] = it.data_value;
         FUNC_CLASS: begin
            if (it.addr < 16) begin
               cls_label[it.addr[3:0]] = it.data_value;
               cls_trees[it.addr[3:0]] = it.tree_count;
               cls_splits[it.addr[3:0]] = it.split_count;
               cls_nbase[it.addr[3:0]] = it.node_base;
               cls_wbase[it.addr[3:0]] = it.weight_base;
            end
         end
         default: begin
            if (fill_index < 256) begin
               features[8'(fill_index)] = it.data_value;
               feature_seen[8'(fill_index)] = 1'b1;
               fill_index++;
            end
            if (it.last_feature) begin
               got = 1'b1;
               v.label = -16'sd1;
               ncls = (classes_reg < 16) ? classes_reg : 16;
               for (int k = 0; k < ncls; k++) begin
                  score = 0;
                  for (int t = 0; t < cls_trees[4'(k)]; t++)
                     score += walk_chain(4'(k), t, v.err);
                  if (score > 0) begin
                     v.hits++;
                     v.label = cls_label[4'(k)];
                  end
               end
               if (v.hits != 1)
                  v.label = -16'sd1;
               fill_index = 0;
            end
         end
      endcase
   endtask

   task automatic feed(input item_type it, input bit typed = 1'b0,
                       input verdict_type want = '0);
      int gap;
      bit got;
      verdict_type v;
      gap = 0;
      if (!no_gaps && $urandom_range(0, 9) >= 6)
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      cur <= it;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      classify_item(it, got, v);
      if (got)
         pending.push_back(typed ? want : v);
      if (it.func != FUNC_CLASS || it.addr < 16)
         items++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
   endtask

   task automatic go_idle();
      drain();
      @(posedge clock);
      while (busy) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_classes(input logic [4:0] n);
      csr_class_count <= n;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      classes_reg = n;
   endtask

   function automatic item_type noise_item();
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      return raw[$bits(item_type)-1:0];
   endfunction

   function automatic item_type mk(input func_type f, input int addr, input int dim,
                                   input int thr, input int lft, input int rgt,
                                   input int dv, input int tc, input int sc,
                                   input int nb, input int wb, input bit last);
      item_type it;
      it.func = f;
      it.addr = 12'(addr);
      it.node_dim = 8'(dim);
      it.node_thr = 16'(thr);
      it.left_leaf = 8'(lft);
      it.right_leaf = 8'(rgt);
      it.data_value = 16'(dv);
      it.tree_count = 9'(tc);
      it.split_count = 8'(sc);
      it.node_base = 12'(nb);
      it.weight_base = 12'(wb);
      it.last_feature = last;
      return it;
   endfunction

   function automatic row_type row(input item_type it, input bit typed = 1'b0,
                                   input int label = -1, input int hits = 0,
                                   input bit err = 1'b0);
      row_type r;
      r.it = it;
      r.typed = typed;
      r.want.label = 16'(label);
      r.want.hits = 5'(hits);
      r.want.err = err;
      return r;
   endfunction

   task automatic random_phase(input int nf);
      int ncls;
      int trees;
      int splits;
      int nptr;
      int wptr;
      int nvec;
      int vlen;
      int dim;
      int r;
      item_type it;
      ncls = (classes_reg < 16) ? classes_reg : 16;
      repeat ($urandom_range(0, 4)) begin
         it = noise_item();
         it.func = FUNC_NODE;
         feed(it);
      end
      nptr = $urandom_range(0, 4095);
      wptr = $urandom_range(0, 4095);
      for (int k = 0; k < ncls; k++) begin
         trees = (ncls > 6) ? $urandom_range(1, 2) : $urandom_range(1, 3);
         splits = (ncls > 6) ? $urandom_range(1, 2) : $urandom_range(1, 3);
         if ($urandom_range(0, 15) == 0) trees = 0;
         if ($urandom_range(0, 15) == 0) splits = 0;
         for (int t = 0; t < trees; t++) begin
            for (int s = 0; s < splits; s++) begin
               it = noise_item();
               it.func = FUNC_NODE;
               it.addr = 12'((nptr + t * splits + s) % 4096);
               dim = $urandom_range(0, nf - 1);
               if ($urandom_range(0, 7) == 0) begin
                  r = $urandom_range(0, 255);
                  if (feature_seen[8'(r)]) dim = r;
               end
               it.node_dim = 8'(dim);
               it.left_leaf = ($urandom_range(0, 3) == 0) ? CHAIN_CODE
                              : 8'($urandom_range(0, splits));
               it.right_leaf = ($urandom_range(0, 3) == 0) ? CHAIN_CODE
                               : 8'($urandom_range(0, splits));
               feed(it);
            end
            for (int l = 0; l <= splits; l++) begin
               it = noise_item();
               it.func = FUNC_WEIGHT;
               it.addr = 12'((wptr + t * (splits + 1) + l) % 4096);
               feed(it);
            end
         end
         it = noise_item();
         it.func = FUNC_CLASS;
         it.addr = 12'(k);
         it.tree_count = 9'(trees);
         it.split_count = 8'(splits);
         it.node_base = 12'(nptr);
         it.weight_base = 12'(wptr);
         feed(it);
         nptr = (nptr + trees * splits) % 4096;
         wptr = (wptr + trees * (splits + 1)) % 4096;
      end
      nvec = $urandom_range(3, 10);
      for (int v = 0; v < nvec; v++) begin
         vlen = (phases == 3 && v == 0) ? 260 : nf;
         for (int i = 0; i < vlen; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               it = noise_item();
               it.func = ($urandom_range(0, 1) == 0) ? FUNC_WEIGHT : FUNC_CLASS;
               if (it.func == FUNC_CLASS) it.addr[11:4] = 8'($urandom_range(1, 255));
               feed(it);
            end
            it = noise_item();
            it.func = FUNC_FEATURE;
            it.last_feature = (i == vlen - 1);
            feed(it);
         end
         vectors++;
         if ($urandom_range(0, 7) == 0)
            drain();
      end
   endtask

   initial begin
      row_type dir[$];
      logic [4:0] cc;
      int pick;
      dir.push_back(row(mk(FUNC_NODE, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0)));
      dir.push_back(row(mk(FUNC_WEIGHT, 0, 0, 0, 0, 0, -5, 0, 0, 0, 0, 0)));
      dir.push_back(row(mk(FUNC_WEIGHT, 1, 0, 0, 0, 0, 7, 0, 0, 0, 0, 0)));
      dir.push_back(row(mk(FUNC_CLASS, 0, 0, 0, 0, 0, 42, 1, 1, 0, 0, 0)));
      dir.push_back(row(mk(FUNC_FEATURE, 0, 0, 0, 0, 0, 3, 0, 0, 0, 0, 1), 1, 42, 1, 0));
      dir.push_back(row(mk(FUNC_FEATURE, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0, 1), 1, -1, 0, 0));
      dir.push_back(row(mk(FUNC_FEATURE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, 42, 1, 0));
      dir.push_back(row(mk(FUNC_NODE, 0, 0, -32768, 255, 255, 0, 0, 0, 0, 0, 0)));
      dir.push_back(row(mk(FUNC_FEATURE, 0, 0, 0, 0, 0, 32767, 0, 0, 0, 0, 1), 1, -1, 0, 1));
      dir.push_back(row(mk(FUNC_CLASS, 0, 0, 0, 0, 0, -32768, 0, 1, 0, 0, 0)));
      dir.push_back(row(mk(FUNC_FEATURE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, -1, 0, 0));
      dir.push_back(row(mk(FUNC_CLASS, 0, 0, 0, 0, 0, 100, 1, 0, 0, 0, 0)));
      dir.push_back(row(mk(FUNC_FEATURE, 0, 0, 0, 0, 0, 5, 0, 0, 0, 0, 1), 1, -1, 0, 1));
      dir.push_back(row(mk(FUNC_NODE, 4095, 0, 32767, 1, 0, 0, 0, 0, 0, 0, 0)));
      dir.push_back(row(mk(FUNC_CLASS, 0, 0, 0, 0, 0, 7, 1, 1, 4095, 4095, 0)));
      dir.push_back(row(mk(FUNC_FEATURE, 0, 0, 0, 0, 0, -1, 0, 0, 0, 0, 1), 1, -1, 0, 0));
      dir.push_back(row(mk(FUNC_WEIGHT, 0, 0, 0, 0, 0, 9, 0, 0, 0, 0, 0)));
      dir.push_back(row(mk(FUNC_FEATURE, 0, 0, 0, 0, 0, -2, 0, 0, 0, 0, 1), 1, 7, 1, 0));
      dir.push_back(row(mk(FUNC_CLASS, 4095, 255, -1, 255, 255, -1, 511, 255, 4095, 4095,
                           1)));
      dir.push_back(row(mk(FUNC_FEATURE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0)));
      dir.push_back(row(mk(FUNC_FEATURE, 0, 0, 0, 0, 0, -32768, 0, 0, 0, 0, 1)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir[i])
         feed(dir[i].it, dir[i].typed, dir[i].want);

      while (items < NUM_ITEMS) begin
         go_idle();
         pick = $urandom_range(0, 7);
         case (pick)
            0: cc = 5'd0;
            1: cc = 5'd1;
            2: cc = 5'd16;
            3: cc = 5'd31;
            default: cc = 5'($urandom_range(0, 31));
         endcase
         if (phases == 3) cc = 5'd2;
         set_classes(cc);
         no_gaps = ($urandom_range(0, 3) == 0);
         random_phase($urandom_range(1, 6));
         phases++;
      end
      no_gaps = 1'b0;
      go_idle();

      $display("%0d items, %0d feature vectors over %0d class settings, %0d results",
               items, vectors, phases, results);
      $display("covered chain overrun, zero trees, address wrap and feature overflow");
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/bscc_pkg.sv
hw/rtl/bscc_front.sv
hw/rtl/bscc_queue.sv
hw/rtl/bscc_back.sv
hw/rtl/boosted_stump_chain_classifier.sv
test/boosted_stump_chain_classifier_test.sv
